// ===== src/eqc_pkg.sv =====
// Shared constants, types and rounding helpers for the Euler/quaternion converter.
package eqc_pkg;

    localparam int ANGLE_BITS     = 16;
    localparam int QUAT_FRAC_BITS = 14;
    localparam int FIELD_BITS     = 16;
    localparam int CORDIC_STEPS   = 30;

    // internal word: 32-bit binary angles and Q30 values with headroom
    localparam int WORD_W = 34;
    localparam int VEC_W  = 45;
    localparam int Q30_W  = 32;
    localparam int PROD_W = 2 * FIELD_BITS;

    // atan2 operand normalisation
    localparam int NORM_LIMIT = 40;
    localparam int NORM_STEPS = 6;
    localparam int MAG_W      = NORM_LIMIT + 1;
    localparam int ATAN_LAT   = 1 + NORM_STEPS + 1 + CORDIC_STEPS;

    // pitch cosine square root
    localparam int SQRT_TOP   = 60;
    localparam int SQRT_STEPS = SQRT_TOP / 2 + 1;
    localparam int SQRT_W     = SQRT_TOP + 2;
    localparam int PITCH_SHIFT = 30 - 2 * QUAT_FRAC_BITS;

    // pipeline bookkeeping
    localparam int PITCH_PRE = 2 + SQRT_STEPS;
    localparam int PIPE_END  = 2 + PITCH_PRE + ATAN_LAT;
    localparam int QUAT_DONE = 1 + CORDIC_STEPS + 5;
    localparam int QUAT_DLY  = PIPE_END - QUAT_DONE;
    localparam int RY_DLY    = PITCH_PRE;

    localparam logic [29:0] ATAN_TURNS [0:CORDIC_STEPS-1] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
        30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
        30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722,
        30'd20861, 30'd10430, 30'd5215, 30'd2608, 30'd1304,
        30'd652, 30'd326, 30'd163, 30'd81, 30'd41,
        30'd20, 30'd10, 30'd5, 30'd3, 30'd1
    };

    typedef logic signed [WORD_W-1:0]   word_t;
    typedef logic signed [VEC_W-1:0]    vec_t;
    typedef logic signed [FIELD_BITS-1:0] field_t;
    typedef logic signed [Q30_W-1:0]    q30_t;
    typedef logic signed [2*Q30_W-1:0]  wide_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic [SQRT_W-1:0]          sq_t;

    typedef enum logic {
        OP_TO_QUAT  = 1'b0,
        OP_TO_EULER = 1'b1
    } op_t;

    typedef struct packed {
        field_t roll;
        field_t pitch;
        field_t yaw;
        field_t qx;
        field_t qy;
        field_t qz;
        field_t qw;
    } res_t;

    localparam word_t CORDIC_GAIN  = word_t'(652032874);
    localparam word_t QUARTER_TURN = word_t'(1) <<< 30;
    localparam word_t SQ_ONE       = word_t'(1) <<< (2 * QUAT_FRAC_BITS);
    localparam word_t Q_ONE        = word_t'(1) <<< QUAT_FRAC_BITS;
    localparam sq_t   SQRT_ONE     = sq_t'(1) << SQRT_TOP;

    function automatic word_t atan_turn(input int idx);
        return word_t'(ATAN_TURNS[idx]);
    endfunction

    // round a Q60 product back to Q30, ties toward plus infinity
    function automatic q30_t rnd_q30(input wide_t v);
        wide_t t;
        t = v + (wide_t'(1) <<< 29);
        return q30_t'(t >>> 30);
    endfunction

    // 32-bit binary angle to field angle
    function automatic field_t angle_fld(input word_t z);
        word_t t;
        t = z + (word_t'(1) <<< (31 - ANGLE_BITS));
        return field_t'(t >>> (32 - ANGLE_BITS));
    endfunction

    // Q30 component to saturated quaternion field
    function automatic field_t quat_sat(input word_t q);
        word_t t;
        word_t v;
        t = q + (word_t'(1) <<< (29 - QUAT_FRAC_BITS));
        v = t >>> (30 - QUAT_FRAC_BITS);
        if (v > Q_ONE)
            v = Q_ONE;
        else if (v < -Q_ONE)
            v = -Q_ONE;
        return field_t'(v);
    endfunction

endpackage

// ===== src/euler_quaternion_converter_unit.sv =====
// Accepts one request per cycle while in_ready is high; the pitch path (square root then atan2)
// sets the depth.
// The whole pipeline advances together; a skid register lets one more result land while
// the output stalls, so the input is held off only once that register is full.
// Reset (rst_n low, asynchronous) clears all valid bits; data registers are not reset.
module euler_quaternion_converter_unit (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic            opcode,
    input  eqc_pkg::field_t angle_x,
    input  eqc_pkg::field_t angle_y,
    input  eqc_pkg::field_t angle_z,
    input  eqc_pkg::field_t quat_x_in,
    input  eqc_pkg::field_t quat_y_in,
    input  eqc_pkg::field_t quat_z_in,
    input  eqc_pkg::field_t quat_w_in,
    output logic            out_valid,
    input  logic            out_ready,
    output eqc_pkg::field_t roll_out,
    output eqc_pkg::field_t pitch_out,
    output eqc_pkg::field_t yaw_out,
    output eqc_pkg::field_t quat_x_out,
    output eqc_pkg::field_t quat_y_out,
    output eqc_pkg::field_t quat_z_out,
    output eqc_pkg::field_t quat_w_out
);
    import eqc_pkg::*;

    logic adv;
    logic vld_reg [1:PIPE_END];
    logic opc_reg [1:PIPE_END];

    // stage 1: half angles and quaternion products
    word_t hax_reg, hay_reg, haz_reg;
    prod_t p_wx_reg, p_yz_reg, p_xx_reg, p_yy_reg, p_wy_reg;
    prod_t p_zx_reg, p_wz_reg, p_xy_reg, p_zz_reg;

    // stage 2: atan2 operands and clamped pitch sine
    word_t roll_y_reg, roll_x_reg, yaw_y_reg, yaw_x_reg;
    word_t roll_y_next, roll_x_next, yaw_y_next, yaw_x_next;
    word_t s_raw, s_clip, s30_w, s30_neg;
    q30_t  s30_reg;
    logic [Q30_W-2:0] sabs_reg;

    // stages 3 and 4 and the square root chain
    sq_t  sq_reg;
    q30_t s30_3_reg;
    sq_t  sv_reg [0:SQRT_STEPS];
    sq_t  sr_reg [0:SQRT_STEPS];
    q30_t ss_reg [0:SQRT_STEPS];

    word_t roll_ang, pitch_ang, yaw_ang;
    word_t rd_reg [1:RY_DLY];
    word_t yd_reg [1:RY_DLY];

    // angle to quaternion path
    word_t sx, cx, sy, cy, sz, cz;
    q30_t  sx_q, cx_q, sy_q, cy_q;
    wide_t m_scy_reg, m_csy_reg, m_ccy_reg, m_ssy_reg;
    q30_t  cz1_reg, sz1_reg, cz2_reg, sz2_reg;
    q30_t  scy_reg, csy_reg, ccy_reg, ssy_reg;
    wide_t m_scy_cz_reg, m_csy_sz_reg, m_csy_cz_reg, m_scy_sz_reg;
    wide_t m_ccy_sz_reg, m_ssy_cz_reg, m_ccy_cz_reg, m_ssy_sz_reg;
    word_t qx_reg, qy_reg, qz_reg, qw_reg;
    field_t fx_reg, fy_reg, fz_reg, fw_reg;
    field_t qdx_reg [1:QUAT_DLY];
    field_t qdy_reg [1:QUAT_DLY];
    field_t qdz_reg [1:QUAT_DLY];
    field_t qdw_reg [1:QUAT_DLY];

    // output side
    res_t fmt_res;
    res_t out_res_reg, skd_res_reg;
    logic out_valid_reg, out_valid_next;
    logic skd_valid_reg, skd_valid_next;
    logic take, push, out_load, out_from_skd, skd_load;

    assign adv      = !skd_valid_reg;
    assign in_ready = adv;

    // advance valid bits with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 1; k <= PIPE_END; k++)
                vld_reg[k] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[1] <= in_valid;
            for (int k = 2; k <= PIPE_END; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            opc_reg[1] <= opcode;
            for (int k = 2; k <= PIPE_END; k++)
                opc_reg[k] <= opc_reg[k-1];
        end
    end

    // stage 1: capture half angles (z negated) and the nine component products
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hax_reg  <= word_t'(angle_x) <<< (31 - ANGLE_BITS);
            hay_reg  <= word_t'(angle_y) <<< (31 - ANGLE_BITS);
            haz_reg  <= (-word_t'(angle_z)) <<< (31 - ANGLE_BITS);
            p_wx_reg <= quat_w_in * quat_x_in;
            p_yz_reg <= quat_y_in * quat_z_in;
            p_xx_reg <= quat_x_in * quat_x_in;
            p_yy_reg <= quat_y_in * quat_y_in;
            p_wy_reg <= quat_w_in * quat_y_in;
            p_zx_reg <= quat_z_in * quat_x_in;
            p_wz_reg <= quat_w_in * quat_z_in;
            p_xy_reg <= quat_x_in * quat_y_in;
            p_zz_reg <= quat_z_in * quat_z_in;
        end
    end

    // stage 2: form the atan2 operands, clamp the pitch sine to one
    always_comb
    begin
        roll_y_next = (word_t'(p_wx_reg) + word_t'(p_yz_reg)) <<< 1;
        roll_x_next = SQ_ONE - ((word_t'(p_xx_reg) + word_t'(p_yy_reg)) <<< 1);
        yaw_y_next  = (word_t'(p_wz_reg) + word_t'(p_xy_reg)) <<< 1;
        yaw_x_next  = SQ_ONE - ((word_t'(p_yy_reg) + word_t'(p_zz_reg)) <<< 1);
        s_raw       = (word_t'(p_wy_reg) - word_t'(p_zx_reg)) <<< 1;
        if (s_raw > SQ_ONE)
            s_clip = SQ_ONE;
        else if (s_raw < -SQ_ONE)
            s_clip = -SQ_ONE;
        else
            s_clip = s_raw;
        s30_w   = s_clip <<< PITCH_SHIFT;
        s30_neg = -s30_w;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            roll_y_reg <= roll_y_next;
            roll_x_reg <= roll_x_next;
            yaw_y_reg  <= yaw_y_next;
            yaw_x_reg  <= yaw_x_next;
            s30_reg    <= q30_t'(s30_w);
            sabs_reg   <= s30_w[WORD_W-1] ? s30_neg[Q30_W-2:0] : s30_w[Q30_W-2:0];
        end
    end

    // stage 3: square the sine; stage 4: one minus the square
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_reg    <= sq_t'(sabs_reg) * sq_t'(sabs_reg);
            s30_3_reg <= s30_reg;
            sv_reg[0] <= SQRT_ONE - sq_reg;
            sr_reg[0] <= '0;
            ss_reg[0] <= s30_3_reg;
        end
    end

    // restoring square root, one result bit per stage
    genvar j;
    for (j = 0; j < SQRT_STEPS; j++)
    begin : g_sqrt
        sq_t bit_w;
        sq_t trial;

        assign bit_w = sq_t'(1) << (SQRT_TOP - 2 * j);
        assign trial = sr_reg[j] + bit_w;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (sv_reg[j] >= trial)
                begin
                    sv_reg[j+1] <= sv_reg[j] - trial;
                    sr_reg[j+1] <= (sr_reg[j] >> 1) + bit_w;
                end
                else
                begin
                    sv_reg[j+1] <= sv_reg[j];
                    sr_reg[j+1] <= sr_reg[j] >> 1;
                end
                ss_reg[j+1] <= ss_reg[j];
            end
        end
    end

    eqc_atan2 u_roll (
        .clk   (clk),
        .en    (adv),
        .y_in  (roll_y_reg),
        .x_in  (roll_x_reg),
        .angle (roll_ang)
    );

    eqc_atan2 u_yaw (
        .clk   (clk),
        .en    (adv),
        .y_in  (yaw_y_reg),
        .x_in  (yaw_x_reg),
        .angle (yaw_ang)
    );

    eqc_atan2 u_pitch (
        .clk   (clk),
        .en    (adv),
        .y_in  (word_t'(ss_reg[SQRT_STEPS])),
        .x_in  (word_t'(sr_reg[SQRT_STEPS][WORD_W-2:0])),
        .angle (pitch_ang)
    );

    // hold roll and yaw until pitch catches up
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rd_reg[1] <= roll_ang;
            yd_reg[1] <= yaw_ang;
            for (int k = 2; k <= RY_DLY; k++)
            begin
                rd_reg[k] <= rd_reg[k-1];
                yd_reg[k] <= yd_reg[k-1];
            end
        end
    end

    eqc_sincos u_sc_x (
        .clk     (clk),
        .en      (adv),
        .angle   (hax_reg),
        .sin_val (sx),
        .cos_val (cx)
    );

    eqc_sincos u_sc_y (
        .clk     (clk),
        .en      (adv),
        .angle   (hay_reg),
        .sin_val (sy),
        .cos_val (cy)
    );

    eqc_sincos u_sc_z (
        .clk     (clk),
        .en      (adv),
        .angle   (haz_reg),
        .sin_val (sz),
        .cos_val (cz)
    );

    assign sx_q = q30_t'(sx);
    assign cx_q = q30_t'(cx);
    assign sy_q = q30_t'(sy);
    assign cy_q = q30_t'(cy);

    // x/y partial products, rounding, then the products with the z terms
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_scy_reg <= wide_t'(sx_q) * wide_t'(cy_q);
            m_csy_reg <= wide_t'(cx_q) * wide_t'(sy_q);
            m_ccy_reg <= wide_t'(cx_q) * wide_t'(cy_q);
            m_ssy_reg <= wide_t'(sx_q) * wide_t'(sy_q);
            cz1_reg   <= q30_t'(cz);
            sz1_reg   <= q30_t'(sz);

            scy_reg <= rnd_q30(m_scy_reg);
            csy_reg <= rnd_q30(m_csy_reg);
            ccy_reg <= rnd_q30(m_ccy_reg);
            ssy_reg <= rnd_q30(m_ssy_reg);
            cz2_reg <= cz1_reg;
            sz2_reg <= sz1_reg;

            m_scy_cz_reg <= wide_t'(scy_reg) * wide_t'(cz2_reg);
            m_csy_sz_reg <= wide_t'(csy_reg) * wide_t'(sz2_reg);
            m_csy_cz_reg <= wide_t'(csy_reg) * wide_t'(cz2_reg);
            m_scy_sz_reg <= wide_t'(scy_reg) * wide_t'(sz2_reg);
            m_ccy_sz_reg <= wide_t'(ccy_reg) * wide_t'(sz2_reg);
            m_ssy_cz_reg <= wide_t'(ssy_reg) * wide_t'(cz2_reg);
            m_ccy_cz_reg <= wide_t'(ccy_reg) * wide_t'(cz2_reg);
            m_ssy_sz_reg <= wide_t'(ssy_reg) * wide_t'(sz2_reg);

            qx_reg <= word_t'(rnd_q30(m_scy_cz_reg)) - word_t'(rnd_q30(m_csy_sz_reg));
            qy_reg <= word_t'(rnd_q30(m_csy_cz_reg)) + word_t'(rnd_q30(m_scy_sz_reg));
            qz_reg <= word_t'(rnd_q30(m_ccy_sz_reg)) - word_t'(rnd_q30(m_ssy_cz_reg));
            qw_reg <= word_t'(rnd_q30(m_ccy_cz_reg)) + word_t'(rnd_q30(m_ssy_sz_reg));

            fx_reg <= quat_sat(qx_reg);
            fy_reg <= quat_sat(qy_reg);
            fz_reg <= quat_sat(qz_reg);
            fw_reg <= quat_sat(qw_reg);
        end
    end

    // hold the quaternion until the Euler path lines up
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            qdx_reg[1] <= fx_reg;
            qdy_reg[1] <= fy_reg;
            qdz_reg[1] <= fz_reg;
            qdw_reg[1] <= fw_reg;
            for (int k = 2; k <= QUAT_DLY; k++)
            begin
                qdx_reg[k] <= qdx_reg[k-1];
                qdy_reg[k] <= qdy_reg[k-1];
                qdz_reg[k] <= qdz_reg[k-1];
                qdw_reg[k] <= qdw_reg[k-1];
            end
        end
    end

    // format the result, zeroing the fields of the operation not requested
    always_comb
    begin
        fmt_res = '0;
        if (opc_reg[PIPE_END] == OP_TO_EULER)
        begin
            fmt_res.roll  = angle_fld(rd_reg[RY_DLY]);
            fmt_res.pitch = angle_fld(pitch_ang);
            fmt_res.yaw   = -angle_fld(yd_reg[RY_DLY]);
        end
        else
        begin
            fmt_res.qx = qdx_reg[QUAT_DLY];
            fmt_res.qy = qdy_reg[QUAT_DLY];
            fmt_res.qz = qdz_reg[QUAT_DLY];
            fmt_res.qw = qdw_reg[QUAT_DLY];
        end
    end

    // output register with one skid entry behind it
    assign take = out_valid_reg && out_ready;
    assign push = adv && vld_reg[PIPE_END];

    always_comb
    begin
        out_valid_next = out_valid_reg;
        skd_valid_next = skd_valid_reg;
        out_load       = 1'b0;
        out_from_skd   = 1'b0;
        skd_load       = 1'b0;
        if (skd_valid_reg)
        begin
            if (take)
            begin
                out_load       = 1'b1;
                out_from_skd   = 1'b1;
                skd_valid_next = 1'b0;
            end
        end
        else if (!out_valid_reg || take)
        begin
            out_valid_next = push;
            out_load       = push;
        end
        else if (push)
        begin
            skd_load       = 1'b1;
            skd_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skd_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            skd_valid_reg <= skd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            out_res_reg <= out_from_skd ? skd_res_reg : fmt_res;
        if (skd_load)
            skd_res_reg <= fmt_res;
    end

    assign out_valid  = out_valid_reg;
    assign roll_out   = out_res_reg.roll;
    assign pitch_out  = out_res_reg.pitch;
    assign yaw_out    = out_res_reg.yaw;
    assign quat_x_out = out_res_reg.qx;
    assign quat_y_out = out_res_reg.qy;
    assign quat_z_out = out_res_reg.qz;
    assign quat_w_out = out_res_reg.qw;

    // the skid entry is only ever occupied behind a waiting output
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skd_valid_reg |-> out_valid_reg)
        else $error("skid entry held without a valid output");

    // the skid entry fills only when the output was stalled
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skd_valid_reg) |-> $past(out_valid_reg && !out_ready))
        else $error("skid entry filled while output was free");

    // an accepted request enters the first stage
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> vld_reg[1])
        else $error("accepted request lost at pipeline entry");

    // a result carries either Euler angles or a quaternion, never both
    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (roll_out != '0 || pitch_out != '0 || yaw_out != '0))
        |-> (quat_x_out == '0 && quat_y_out == '0 && quat_z_out == '0 && quat_w_out == '0))
        else $error("result mixes angle and quaternion fields");

endmodule

// ===== src/eqc_sincos.sv =====
// Pipelined rotation-mode CORDIC: sine and cosine of a half angle, one step per stage.
module eqc_sincos (
    input  logic           clk,
    input  logic           en,
    input  eqc_pkg::word_t angle,
    output eqc_pkg::word_t sin_val,
    output eqc_pkg::word_t cos_val
);
    import eqc_pkg::*;

    word_t x_stage [0:CORDIC_STEPS];
    word_t y_stage [0:CORDIC_STEPS];
    word_t z_stage [0:CORDIC_STEPS];
    word_t x_reg   [1:CORDIC_STEPS];
    word_t y_reg   [1:CORDIC_STEPS];
    word_t z_reg   [1:CORDIC_STEPS];

    // seed the first stage with the gain-corrected unit vector
    assign x_stage[0] = CORDIC_GAIN;
    assign y_stage[0] = '0;
    assign z_stage[0] = angle;

    genvar i;
    for (i = 1; i <= CORDIC_STEPS; i++)
    begin : g_tap
        assign x_stage[i] = x_reg[i];
        assign y_stage[i] = y_reg[i];
        assign z_stage[i] = z_reg[i];
    end

    // one micro-rotation per stage, direction from the residual angle
    for (i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        word_t x_next;
        word_t y_next;
        word_t z_next;

        always_comb
        begin
            if (!z_stage[i][WORD_W-1])
            begin
                x_next = x_stage[i] - (y_stage[i] >>> i);
                y_next = y_stage[i] + (x_stage[i] >>> i);
                z_next = z_stage[i] - atan_turn(i);
            end
            else
            begin
                x_next = x_stage[i] + (y_stage[i] >>> i);
                y_next = y_stage[i] - (x_stage[i] >>> i);
                z_next = z_stage[i] + atan_turn(i);
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i+1] <= x_next;
                y_reg[i+1] <= y_next;
                z_reg[i+1] <= z_next;
            end
        end
    end

    assign sin_val = y_stage[CORDIC_STEPS];
    assign cos_val = x_stage[CORDIC_STEPS];

endmodule

// ===== src/eqc_atan2.sv =====
// Pipelined atan2: operand normalisation, quadrant fold and vectoring-mode CORDIC.
module eqc_atan2 (
    input  logic           clk,
    input  logic           en,
    input  eqc_pkg::word_t y_in,
    input  eqc_pkg::word_t x_in,
    output eqc_pkg::word_t angle
);
    import eqc_pkg::*;

    vec_t             nx_reg [0:NORM_STEPS];
    vec_t             ny_reg [0:NORM_STEPS];
    logic [MAG_W-1:0] nm_reg [0:NORM_STEPS];
    logic             nz_reg [0:NORM_STEPS];

    vec_t  cx_reg [0:CORDIC_STEPS];
    vec_t  cy_reg [0:CORDIC_STEPS];
    word_t cz_reg [0:CORDIC_STEPS];
    logic  cf_reg [0:CORDIC_STEPS];

    logic [WORD_W-1:0] ax;
    logic [WORD_W-1:0] ay;
    vec_t  xd;
    vec_t  yd;
    vec_t  qx;
    vec_t  qy;
    word_t qz;

    // take magnitudes and flag the all-zero operand pair
    always_comb
    begin
        ax = x_in[WORD_W-1] ? WORD_W'(-x_in) : WORD_W'(x_in);
        ay = y_in[WORD_W-1] ? WORD_W'(-y_in) : WORD_W'(y_in);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nx_reg[0] <= vec_t'(x_in);
            ny_reg[0] <= vec_t'(y_in);
            nm_reg[0] <= MAG_W'((ax > ay) ? ax : ay);
            nz_reg[0] <= (x_in == '0) && (y_in == '0);
        end
    end

    // binary search of the doubling count, largest step first
    genvar k;
    for (k = 0; k < NORM_STEPS; k++)
    begin : g_norm
        localparam int SH = 1 << (NORM_STEPS - 1 - k);
        logic fits;

        assign fits = (nm_reg[k] >> (NORM_LIMIT - SH)) == '0;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                nx_reg[k+1] <= fits ? (nx_reg[k] <<< SH) : nx_reg[k];
                ny_reg[k+1] <= fits ? (ny_reg[k] <<< SH) : ny_reg[k];
                nm_reg[k+1] <= fits ? (nm_reg[k] << SH) : nm_reg[k];
                nz_reg[k+1] <= nz_reg[k];
            end
        end
    end

    // final doubling, then fold the left half plane by a quarter turn
    always_comb
    begin
        xd = nx_reg[NORM_STEPS] <<< 1;
        yd = ny_reg[NORM_STEPS] <<< 1;
        if (xd[VEC_W-1])
        begin
            if (!yd[VEC_W-1])
            begin
                qx = yd;
                qy = -xd;
                qz = QUARTER_TURN;
            end
            else
            begin
                qx = -yd;
                qy = xd;
                qz = -QUARTER_TURN;
            end
        end
        else
        begin
            qx = xd;
            qy = yd;
            qz = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cx_reg[0] <= qx;
            cy_reg[0] <= qy;
            cz_reg[0] <= qz;
            cf_reg[0] <= nz_reg[NORM_STEPS];
        end
    end

    // drive y toward zero, accumulating the angle
    genvar i;
    for (i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        vec_t  x_next;
        vec_t  y_next;
        word_t z_next;

        always_comb
        begin
            if (!cy_reg[i][VEC_W-1] && (cy_reg[i] != '0))
            begin
                x_next = cx_reg[i] + (cy_reg[i] >>> i);
                y_next = cy_reg[i] - (cx_reg[i] >>> i);
                z_next = cz_reg[i] + atan_turn(i);
            end
            else
            begin
                x_next = cx_reg[i] - (cy_reg[i] >>> i);
                y_next = cy_reg[i] + (cx_reg[i] >>> i);
                z_next = cz_reg[i] - atan_turn(i);
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                cx_reg[i+1] <= x_next;
                cy_reg[i+1] <= y_next;
                cz_reg[i+1] <= z_next;
                cf_reg[i+1] <= cf_reg[i];
            end
        end
    end

    assign angle = cf_reg[CORDIC_STEPS] ? '0 : cz_reg[CORDIC_STEPS];

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the Euler angle / quaternion converter unit.
module testbench;
    import eqc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 200;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        op_t    op;
        field_t ax, ay, az;
        field_t qx, qy, qz, qw;
        bit     drain;
    } request_t;

    localparam longint GAIN_Q30 = 64'sd652032874;
    localparam longint QTURN    = 64'sd1 <<< 30;

    logic   clk;
    logic   rst_n;
    logic   in_valid;
    logic   in_ready;
    logic   opcode;
    field_t angle_x, angle_y, angle_z;
    field_t quat_x_in, quat_y_in, quat_z_in, quat_w_in;
    logic   out_valid;
    logic   out_ready;
    field_t roll_out, pitch_out, yaw_out;
    field_t quat_x_out, quat_y_out, quat_z_out, quat_w_out;

    request_t pending_requests[$];
    res_t     expected_results[$];
    int       mismatches = 0;
    int       cycle_count = 0;
    int       burst_left;
    int       gap_left;
    int       ready_pct;
    int       ready_phase;

    euler_quaternion_converter_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .opcode(opcode),
        .angle_x(angle_x), .angle_y(angle_y), .angle_z(angle_z),
        .quat_x_in(quat_x_in), .quat_y_in(quat_y_in),
        .quat_z_in(quat_z_in), .quat_w_in(quat_w_in),
        .out_valid(out_valid), .out_ready(out_ready),
        .roll_out(roll_out), .pitch_out(pitch_out), .yaw_out(yaw_out),
        .quat_x_out(quat_x_out), .quat_y_out(quat_y_out),
        .quat_z_out(quat_z_out), .quat_w_out(quat_w_out)
    );

    // ---------------- predictor ----------------

    function automatic longint round_sh(input longint v, input int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint mul_q30(input longint a, input longint b);
        return round_sh(a * b, 30);
    endfunction

    function automatic longint abs64(input longint v);
        return v < 0 ? -v : v;
    endfunction

    // rotation mode CORDIC, z within a quarter turn either side
    function automatic void cordic_sincos(input longint z, output longint s, output longint c);
        longint x, y, xn;
        x = GAIN_Q30;
        y = 0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (z >= 0) begin
                xn = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - longint'(ATAN_TURNS[i]);
            end
            else begin
                xn = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + longint'(ATAN_TURNS[i]);
            end
            x = xn;
        end
        s = y;
        c = x;
    endfunction

    // vectoring mode CORDIC, angle of (x, y) in 2^32 units per turn
    function automatic longint cordic_atan2(input longint y, input longint x);
        longint z, t;
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        while (abs64(x) < (64'sd1 <<< 40) && abs64(y) < (64'sd1 <<< 40)) begin
            x = x * 2;
            y = y * 2;
        end
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y; y = -t; z = QTURN;
            end
            else begin
                x = -y; y = t; z = -QTURN;
            end
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (y > 0) begin
                t = x + (y >>> i);
                y = y - (x >>> i);
                z = z + longint'(ATAN_TURNS[i]);
            end
            else begin
                t = x - (y >>> i);
                y = y + (x >>> i);
                z = z - longint'(ATAN_TURNS[i]);
            end
            x = t;
        end
        return z;
    endfunction

    function automatic longint int_sqrt(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    function automatic field_t to_angle(input longint turns, input bit negate);
        longint r;
        r = round_sh(turns, 32 - ANGLE_BITS);
        if (negate)
            r = -r;
        return field_t'(r);
    endfunction

    function automatic field_t to_quat(input longint q30);
        longint v;
        v = round_sh(q30, 30 - QUAT_FRAC_BITS);
        if (v > (64'sd1 <<< QUAT_FRAC_BITS))
            v = 64'sd1 <<< QUAT_FRAC_BITS;
        else if (v < -(64'sd1 <<< QUAT_FRAC_BITS))
            v = -(64'sd1 <<< QUAT_FRAC_BITS);
        return field_t'(v);
    endfunction

    function automatic longint half_turns(input field_t a, input bit negate);
        longint v;
        v = longint'(a);
        if (negate)
            v = -v;
        return v * (64'sd1 <<< (31 - ANGLE_BITS));
    endfunction

    function automatic res_t convert_request(input request_t r);
        res_t   o;
        longint sx, cx, sy, cy, sz, cz, scy, csy, ccy, ssy;
        longint x, y, z, w, one, s, c;
        o = '0;
        if (r.op == OP_TO_QUAT) begin
            cordic_sincos(half_turns(r.ax, 1'b0), sx, cx);
            cordic_sincos(half_turns(r.ay, 1'b0), sy, cy);
            cordic_sincos(half_turns(r.az, 1'b1), sz, cz);
            scy = mul_q30(sx, cy);
            csy = mul_q30(cx, sy);
            ccy = mul_q30(cx, cy);
            ssy = mul_q30(sx, sy);
            o.qx = to_quat(mul_q30(scy, cz) - mul_q30(csy, sz));
            o.qy = to_quat(mul_q30(csy, cz) + mul_q30(scy, sz));
            o.qz = to_quat(mul_q30(ccy, sz) - mul_q30(ssy, cz));
            o.qw = to_quat(mul_q30(ccy, cz) + mul_q30(ssy, sz));
        end
        else begin
            x = longint'(r.qx);
            y = longint'(r.qy);
            z = longint'(r.qz);
            w = longint'(r.qw);
            one = 64'sd1 <<< (2 * QUAT_FRAC_BITS);
            o.roll = to_angle(cordic_atan2(2 * (w * x + y * z),
                                           one - 2 * (x * x + y * y)), 1'b0);
            s = 2 * (w * y - z * x);
            if (s > one) s = one;
            if (s < -one) s = -one;
            s = s * (64'sd1 <<< (30 - 2 * QUAT_FRAC_BITS));
            if (s > QTURN) s = QTURN;
            if (s < -QTURN) s = -QTURN;
            c = int_sqrt((64'd1 << 60) - longint'(s * s));
            o.pitch = to_angle(cordic_atan2(s, c), 1'b0);
            o.yaw = to_angle(cordic_atan2(2 * (w * z + x * y),
                                          one - 2 * (y * y + z * z)), 1'b1);
        end
        return o;
    endfunction

    // ---------------- stimulus ----------------

    function automatic request_t angles_request(input int ax, input int ay, input int az);
        request_t r;
        r = '{OP_TO_QUAT, field_t'(ax), field_t'(ay), field_t'(az), 0, 0, 0, 0, 1'b0};
        return r;
    endfunction

    function automatic request_t quat_request(input int qx, input int qy,
                                              input int qz, input int qw);
        request_t r;
        r = '{OP_TO_EULER, 0, 0, 0, field_t'(qx), field_t'(qy), field_t'(qz),
              field_t'(qw), 1'b0};
        return r;
    endfunction

    function automatic field_t rand_field();
        return field_t'($urandom);
    endfunction

    function automatic int rand_quat_comp();
        return $urandom_range(0, 32768) - 16384;
    endfunction

    function automatic request_t random_request();
        request_t r;
        res_t     q;
        int       pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            r = angles_request(rand_field(), rand_field(), rand_field());
        else if (pick < 70) begin
            // well-formed unit quaternion built from random angles
            q = convert_request(angles_request(rand_field(), rand_field(), rand_field()));
            r = quat_request(q.qx, q.qy, q.qz, q.qw);
        end
        else if (pick < 85)
            r = quat_request(rand_quat_comp(), rand_quat_comp(), rand_quat_comp(),
                             rand_quat_comp());
        else
            r = quat_request(rand_field(), rand_field(), rand_field(), rand_field());
        // random values into ax, qx and qw, some of which the operation uses
        if ($urandom_range(0, 3) == 0) begin
            r.ax = rand_field(); r.qx = rand_field(); r.qw = rand_field();
        end
        return r;
    endfunction

    // ---------------- clock and reset ----------------

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial
    begin
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ---------------- driver ----------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            opcode     <= OP_TO_QUAT;
            angle_x    <= '0; angle_y <= '0; angle_z <= '0;
            quat_x_in  <= '0; quat_y_in <= '0; quat_z_in <= '0; quat_w_in <= '0;
            burst_left <= 1;
            gap_left   <= 0;
        end
        else
        begin
            // record the prediction for a request taken at this edge
            if (in_valid && in_ready)
                expected_results.push_back(convert_request('{op_t'(opcode),
                    angle_x, angle_y, angle_z, quat_x_in, quat_y_in, quat_z_in,
                    quat_w_in, 1'b0}));
            if (in_valid && !in_ready)
            begin
                // hold the request until taken
            end
            else if (gap_left > 0)
            begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_requests.size() > 0 &&
                     (!pending_requests[0].drain ||
                      (expected_results.size() == 0 && !in_valid)))
            begin
                request_t r;
                r = pending_requests.pop_front();
                in_valid  <= 1'b1;
                opcode    <= r.op;
                angle_x   <= r.ax; angle_y <= r.ay; angle_z <= r.az;
                quat_x_in <= r.qx; quat_y_in <= r.qy;
                quat_z_in <= r.qz; quat_w_in <= r.qw;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // ---------------- output stall pattern ----------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready   <= 1'b0;
            ready_pct   <= 100;
            ready_phase <= 0;
        end
        else
        begin
            // change the stall density whenever the phase counter runs out
            if (ready_phase == 0)
            begin
                ready_phase <= $urandom_range(50, 300);
                case ($urandom_range(0, 3))
                    0: ready_pct <= 100;
                    1: ready_pct <= 80;
                    2: ready_pct <= 40;
                    default: ready_pct <= 10;
                endcase
            end
            else
                ready_phase <= ready_phase - 1;
            out_ready <= ($urandom_range(1, 100) <= ready_pct);
        end
    end

    // ---------------- monitor ----------------

    function automatic bit field_ok(input string name, input field_t want, input field_t got);
        if (want === got)
            return 1'b1;
        if (mismatches < MAX_REPORTS)
            $display("mismatch %s: expected %0d, got %0d", name, want, got);
        return 1'b0;
    endfunction

    always @(posedge clk)
    begin
        res_t want;
        bit   ok;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                if (mismatches < MAX_REPORTS)
                    $display("unexpected result with nothing outstanding");
                mismatches <= mismatches + 1;
            end
            else
            begin
                want = expected_results.pop_front();
                ok = 1'b1;
                ok &= field_ok("roll", want.roll, roll_out);
                ok &= field_ok("pitch", want.pitch, pitch_out);
                ok &= field_ok("yaw", want.yaw, yaw_out);
                ok &= field_ok("quat_x", want.qx, quat_x_out);
                ok &= field_ok("quat_y", want.qy, quat_y_out);
                ok &= field_ok("quat_z", want.qz, quat_z_out);
                ok &= field_ok("quat_w", want.qw, quat_w_out);
                if (!ok)
                    mismatches <= mismatches + 1;
            end
        end
    end

    // ---------------- watchdog ----------------

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[euler_quaternion_converter_unit] ERROR");
            $finish;
        end
    end

    // ---------------- sequence ----------------

    initial
    begin
        request_t r;

        // extremes, Z negation at minus half turn, wrap beyond half turn
        pending_requests.push_back(angles_request(0, 0, 0));
        pending_requests.push_back(angles_request(-32768, -32768, -32768));
        pending_requests.push_back(angles_request(32767, 32767, 32767));
        pending_requests.push_back(angles_request(0, 0, -32768));
        pending_requests.push_back(angles_request(16384, -16384, 8192));
        pending_requests.push_back(angles_request(-1, 1, -1));
        pending_requests.push_back(angles_request(32767, -32768, 0));
        // identity, zero quaternion (every atan2 y operand zero), non-unit inputs
        pending_requests.push_back(quat_request(0, 0, 0, 16384));
        pending_requests.push_back(quat_request(0, 0, 0, 0));
        pending_requests.push_back(quat_request(16384, 16384, 16384, 16384));
        pending_requests.push_back(quat_request(-16384, -16384, -16384, -16384));
        // pitch near and beyond the asin clamp, either sign
        pending_requests.push_back(quat_request(0, 11585, 0, 11585));
        pending_requests.push_back(quat_request(0, -11585, 0, 11585));
        pending_requests.push_back(quat_request(16384, 16384, -16384, 16384));
        // half-turn roll and yaw
        pending_requests.push_back(quat_request(16384, 0, 0, 0));
        pending_requests.push_back(quat_request(0, 0, 16384, 0));
        pending_requests.push_back(quat_request(-16384, 0, 0, 1));
        // full field range outside Q2.14 unity
        pending_requests.push_back(quat_request(-32768, 32767, -32768, 32767));
        pending_requests.push_back(quat_request(32767, -32768, 32767, -32768));
        pending_requests.push_back(quat_request(1, -1, 1, -1));

        for (int i = 0; i < 1700; i++)
        begin
            r = random_request();
            // let the pipeline drain now and then
            r.drain = (i % 400 == 0);
            pending_requests.push_back(r);
        end

        wait (rst_n === 1'b1);
        while (pending_requests.size() > 0 || in_valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0 && expected_results.size() == 0)
            $display("[euler_quaternion_converter_unit] OK");
        else
            $display("[euler_quaternion_converter_unit] ERROR");
        $finish;
    end

endmodule
